>>> sv/trcq_pkg.sv
// Shared types, codes and constants of the touch report coalescing queue.
// No dependencies; every other file takes names from here by scope.
package trcq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int RAW_W           = 15;
   localparam int RES_W           = 12;
   localparam int PROD_W          = RAW_W + RES_W;
   localparam int RAW_MAX         = 32767;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = RES_W;

   localparam logic [RES_W-1:0] WIDTH_RESET  = 12'd1986;
   localparam logic [RES_W-1:0] HEIGHT_RESET = 12'd2648;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIRROR_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIRROR_Y = 2'd3;

   localparam logic [1:0] EV_DOWN    = 2'd0;
   localparam logic [1:0] EV_UP      = 2'd1;
   localparam logic [1:0] EV_CONTACT = 2'd2;

   typedef enum logic [1:0] {
      CMD_SNAPSHOT = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_CONSUME  = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ISSUE,
      B_WAIT,
      B_DECIDE,
      B_READ,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [1:0]       command;
      logic             touch0_down;
      logic [RAW_W-1:0] touch0_x;
      logic [RAW_W-1:0] touch0_y;
      logic             touch1_down;
      logic [RAW_W-1:0] touch1_x;
      logic [RAW_W-1:0] touch1_y;
   } req_type;

   typedef struct packed {
      logic             irq_line;
      logic [1:0]       entry_count;
      logic [1:0]       finger_count;
      logic [1:0]       first_event;
      logic             first_slot;
      logic [RES_W-1:0] first_x;
      logic [RES_W-1:0] first_y;
      logic [1:0]       second_event;
      logic             second_slot;
      logic [RES_W-1:0] second_x;
      logic [RES_W-1:0] second_y;
      logic             overrun;
   } rsp_type;

   typedef struct packed {
      logic             down;
      logic [RAW_W-1:0] x;
      logic [RAW_W-1:0] y;
   } sample_type;

   typedef struct packed {
      cmd_kind_type    kind;
      sample_type [1:0] s;
   } cmd_type;

   typedef struct packed {
      logic [1:0][1:0]       ev;
      logic [1:0]            slot;
      logic [1:0][RES_W-1:0] x;
      logic [1:0][RES_W-1:0] y;
      logic [1:0]            n_entries;
      logic [1:0]            fingers;
      logic [1:0]            mask;
   } report_type;

   typedef struct packed {
      logic             start;
      logic [RAW_W-1:0] raw;
      logic [RES_W-1:0] res;
      logic             mirror;
   } scale_req_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] value;
   } scale_rsp_type;

endpackage

>>> sv/touch_report_coalescing_queue_core.sv
// Top level of the touch report coalescing queue.
// Depends on trcq_pkg, trcq_fifo, trcq_front, trcq_back, trcq_scaler.
//
// Usage:
//   Input channel (req_): a queue. An item (snapshot, scan tick, consume or
//   clear) is taken on a clock edge with req_push high and req_full low.
//   Result channel (rsp_): a queue. Every item yields exactly one result, the
//   report state after that command; it is shown while rsp_empty is low and
//   taken on an edge with rsp_pop high.
//   Configuration (csr_): write-only; csr_index 0 width, 1 height,
//   2 mirror x, 3 mirror y, written on an edge with csr_write high.
// Sequencing:
//   Tick, consume and clear go through the pop, one store read and one result
//   push in the back end. A snapshot adds four axis scalings on one shared
//   two-stage multiplier and one decide/write step between pop and read.
//   Items run one at a time through the back end; a two-entry input queue
//   and a two-entry result queue decouple the neighbors.
// Reset (synchronous, active high): both queues empty, queue pointers,
//   last sample and active flag zero, configuration to 1986/2648/1/1.
//   The report store is not cleared; only written entries are ever read.
// Receiver stall: results pile up in the result queue; when it is full the
//   back end holds, the input queue fills, and req_full rises.
module touch_report_coalescing_queue_core #(
   parameter int QUEUE_DEPTH = trcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  trcq_pkg::req_type               req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output trcq_pkg::rsp_type               rsp_data,
   input  logic                            csr_write,
   input  logic [trcq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [trcq_pkg::CSR_DATA_W-1:0] csr_data
);

   trcq_pkg::cmd_type cmd;
   trcq_pkg::rsp_type out_data;
   logic              cmd_valid, cmd_pop, out_full, out_push;

   // Front: buffer and classify incoming items.
   trcq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // Back: scale, coalesce or append, pop, and image the active report.
   trcq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // Result queue.
   trcq_fifo #(.WIDTH($bits(trcq_pkg::rsp_type))) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

>>> sv/trcq_fifo.sv
// Two-entry FIFO of plain bit vectors, used on both channels of the block.
// Depends on nothing.
module trcq_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [1:0][WIDTH-1:0] mem_ff;
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            cnt_ff;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> sv/trcq_front.sv
// Front end: input queue and command classification.
// Depends on trcq_pkg and trcq_fifo.
module trcq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  trcq_pkg::req_type req_data,
   output logic              req_full,
   input  logic              cmd_pop,
   output logic              cmd_valid,
   output trcq_pkg::cmd_type cmd
);

   trcq_pkg::req_type head;
   logic              empty;

   trcq_fifo #(.WIDTH($bits(trcq_pkg::req_type))) u_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (head),
      .empty     (empty)
   );

   assign cmd_valid = !empty;

   always_comb begin
      unique case (head.command)
         trcq_pkg::CMD_SNAPSHOT: cmd.kind = trcq_pkg::CMD_SNAPSHOT;
         trcq_pkg::CMD_TICK:     cmd.kind = trcq_pkg::CMD_TICK;
         trcq_pkg::CMD_CONSUME:  cmd.kind = trcq_pkg::CMD_CONSUME;
         default:                cmd.kind = trcq_pkg::CMD_CLEAR;
      endcase
      cmd.s[0] = '{down: head.touch0_down, x: head.touch0_x, y: head.touch0_y};
      cmd.s[1] = '{down: head.touch1_down, x: head.touch1_x, y: head.touch1_y};
   end

endmodule

>>> sv/trcq_scaler.sv
// Two-stage axis scaler: raw * (res - 1) / 32767, optional mirror res - s.
// Depends on trcq_pkg.
module trcq_scaler (
   input  logic                    clock,
   input  logic                    reset,
   input  trcq_pkg::scale_req_type sreq,
   output trcq_pkg::scale_rsp_type srsp
);

   localparam int PW = trcq_pkg::PROD_W;
   localparam int RW = trcq_pkg::RES_W;
   localparam int LW = trcq_pkg::RAW_W;

   logic          v1_ff, v2_ff;
   logic [PW-1:0] prod_ff;
   logic [RW-1:0] res1_ff, val_ff;
   logic          mir1_ff;
   logic [RW-1:0] res_m1, q0, q, s;
   logic [LW:0]   rem;

   assign res_m1 = (sreq.res == '0) ? '0 : sreq.res - 1'b1;

   // 32767 = 2^15 - 1: quotient estimate is p >> 15, remainder low + q0,
   // which stays below twice the divisor, so one correction step.
   assign q0  = prod_ff[PW-1:LW];
   assign rem = {1'b0, prod_ff[LW-1:0]} + (LW+1)'(q0);
   assign q   = q0 + RW'(rem >= (LW+1)'(trcq_pkg::RAW_MAX));
   assign s   = mir1_ff ? res1_ff - q : q;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= sreq.start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(sreq.raw) * PW'(res_m1);
      res1_ff <= sreq.res;
      mir1_ff <= sreq.mirror;
      val_ff  <= s;
   end

   assign srsp.done  = v2_ff;
   assign srsp.value = val_ff;

endmodule

>>> sv/trcq_back.sv
// Back end: sequencer, report store, queue pointers and configuration.
// Depends on trcq_pkg and trcq_scaler.
module trcq_back #(
   parameter int QUEUE_DEPTH = trcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [trcq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trcq_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                cmd_valid,
   input  trcq_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   input  logic                                out_full,
   output logic                                out_push,
   output trcq_pkg::rsp_type                   out_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int RW    = trcq_pkg::RES_W;

   trcq_pkg::report_type mem [QUEUE_DEPTH];
   trcq_pkg::report_type rd_head_ff, rd_last_ff, rep;

   trcq_pkg::back_state_type state_ff, state_in;
   trcq_pkg::cmd_type        cmd_ff;
   trcq_pkg::sample_type [1:0] last_ff;
   logic [1:0]               axis_ff;
   logic [1:0][RW-1:0]       sx_ff, sy_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     busy_ff, overrun_ff;
   logic [RW-1:0]            width_ff, height_ff;
   logic                     mirror_x_ff, mirror_y_ff;

   trcq_pkg::scale_req_type  sreq;
   trcq_pkg::scale_rsp_type  srsp;

   logic [SUM_W-1:0] sum, tail;
   logic [IDX_W-1:0] tail_idx, last_idx, head_next;
   logic             has0, has1, changed, transition, motion, coalesce, do_write;
   logic [IDX_W-1:0] wr_idx;
   logic [1:0]       ev0, ev1;

   trcq_scaler u_scale (.clock(clock), .reset(reset), .sreq(sreq), .srsp(srsp));

   // Queue pointers.
   assign sum       = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (sum >= SUM_W'(QUEUE_DEPTH)) ? sum - SUM_W'(QUEUE_DEPTH) : sum;
   assign tail_idx  = tail[IDX_W-1:0];
   assign last_idx  = (tail_idx == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_idx - 1'b1;
   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Scaler feed: axis 0 x0, 1 y0, 2 x1, 3 y1.
   always_comb begin
      sreq.start  = (state_ff == trcq_pkg::B_ISSUE);
      sreq.raw    = axis_ff[0] ? cmd_ff.s[axis_ff[1]].y : cmd_ff.s[axis_ff[1]].x;
      sreq.res    = axis_ff[0] ? height_ff : width_ff;
      sreq.mirror = axis_ff[0] ? mirror_y_ff : mirror_x_ff;
   end

   // Report build and coalescing decision.
   always_comb begin
      has0 = cmd_ff.s[0].down || last_ff[0].down;
      has1 = cmd_ff.s[1].down || last_ff[1].down;
      ev0  = !cmd_ff.s[0].down ? trcq_pkg::EV_UP :
             (last_ff[0].down ? trcq_pkg::EV_CONTACT : trcq_pkg::EV_DOWN);
      ev1  = !cmd_ff.s[1].down ? trcq_pkg::EV_UP :
             (last_ff[1].down ? trcq_pkg::EV_CONTACT : trcq_pkg::EV_DOWN);
      changed = 1'b0;
      transition = 1'b0;
      for (int i = 0; i < 2; i++) begin
         if (cmd_ff.s[i].down != last_ff[i].down) begin
            changed = 1'b1;
            transition = 1'b1;
         end
         if (cmd_ff.s[i].down && (cmd_ff.s[i].x != last_ff[i].x ||
                                  cmd_ff.s[i].y != last_ff[i].y)) changed = 1'b1;
      end
      rep           = '0;
      rep.mask      = {cmd_ff.s[1].down, cmd_ff.s[0].down};
      rep.fingers   = {1'b0, cmd_ff.s[0].down} + {1'b0, cmd_ff.s[1].down};
      rep.n_entries = {1'b0, has0} + {1'b0, has1};
      if (has0) begin
         rep.ev[0] = ev0;
         rep.x[0]  = sx_ff[0];
         rep.y[0]  = sy_ff[0];
         if (has1) begin
            rep.ev[1]   = ev1;
            rep.slot[1] = 1'b1;
            rep.x[1]    = sx_ff[1];
            rep.y[1]    = sy_ff[1];
         end
      end else if (has1) begin
         rep.ev[0]   = ev1;
         rep.slot[0] = 1'b1;
         rep.x[0]    = sx_ff[1];
         rep.y[0]    = sy_ff[1];
      end
      motion = !(rd_last_ff.n_entries != 2'd0 && rd_last_ff.ev[0] != trcq_pkg::EV_CONTACT)
            && !(rd_last_ff.n_entries >= 2'd2 && rd_last_ff.ev[1] != trcq_pkg::EV_CONTACT);
      coalesce = !transition && (count_ff > CNT_W'(busy_ff)) && motion
              && (rd_last_ff.mask == rep.mask);
      do_write = (state_ff == trcq_pkg::B_DECIDE) && changed &&
                 (coalesce || count_ff < CNT_W'(QUEUE_DEPTH));
      wr_idx   = coalesce ? last_idx : tail_idx;
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[wr_idx] <= rep;
      rd_head_ff <= mem[head_ff];
      rd_last_ff <= mem[last_idx];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= trcq_pkg::B_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         trcq_pkg::B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = (cmd.kind == trcq_pkg::CMD_SNAPSHOT) ? trcq_pkg::B_ISSUE
                                                               : trcq_pkg::B_READ;
            end
         end
         trcq_pkg::B_ISSUE:  state_in = trcq_pkg::B_WAIT;
         trcq_pkg::B_WAIT: begin
            if (srsp.done) state_in = (axis_ff == 2'd3) ? trcq_pkg::B_DECIDE
                                                        : trcq_pkg::B_ISSUE;
         end
         trcq_pkg::B_DECIDE: state_in = trcq_pkg::B_READ;
         trcq_pkg::B_READ:   state_in = trcq_pkg::B_OUT;
         trcq_pkg::B_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = trcq_pkg::B_IDLE;
            end
         end
         default: state_in = trcq_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         overrun_ff  <= 1'b0;
         last_ff     <= '0;
         axis_ff     <= 2'd0;
         width_ff    <= trcq_pkg::WIDTH_RESET;
         height_ff   <= trcq_pkg::HEIGHT_RESET;
         mirror_x_ff <= 1'b1;
         mirror_y_ff <= 1'b1;
      end else begin
         if (csr_write) begin
            case (csr_index)
               trcq_pkg::REG_WIDTH:    width_ff    <= csr_data;
               trcq_pkg::REG_HEIGHT:   height_ff   <= csr_data;
               trcq_pkg::REG_MIRROR_X: mirror_x_ff <= csr_data[0];
               default:                mirror_y_ff <= csr_data[0];
            endcase
         end
         if (state_ff == trcq_pkg::B_IDLE && cmd_valid) begin
            overrun_ff <= 1'b0;
            axis_ff    <= 2'd0;
            unique case (cmd.kind)
               trcq_pkg::CMD_TICK: begin
                  if (!busy_ff && count_ff != '0) busy_ff <= 1'b1;
               end
               trcq_pkg::CMD_CONSUME: begin
                  if (busy_ff) begin
                     busy_ff <= 1'b0;
                     head_ff <= head_next;
                     if (count_ff != '0) count_ff <= count_ff - 1'b1;
                  end
               end
               trcq_pkg::CMD_CLEAR: begin
                  last_ff  <= '0;
                  head_ff  <= '0;
                  count_ff <= '0;
                  busy_ff  <= 1'b0;
               end
               default: ;
            endcase
         end
         if (state_ff == trcq_pkg::B_WAIT && srsp.done) axis_ff <= axis_ff + 1'b1;
         if (state_ff == trcq_pkg::B_DECIDE && changed) begin
            if (coalesce) begin
               last_ff <= cmd_ff.s;
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               overrun_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
               last_ff  <= cmd_ff.s;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == trcq_pkg::B_IDLE && cmd_valid) cmd_ff <= cmd;
      if (state_ff == trcq_pkg::B_WAIT && srsp.done) begin
         if (axis_ff[0]) sy_ff[axis_ff[1]] <= srsp.value;
         else            sx_ff[axis_ff[1]] <= srsp.value;
      end
   end

   // Result image of the state after the command.
   always_comb begin
      out_data          = '0;
      out_data.irq_line = !busy_ff;
      out_data.overrun  = overrun_ff;
      if (busy_ff) begin
         out_data.entry_count  = rd_head_ff.n_entries;
         out_data.finger_count = rd_head_ff.fingers;
         out_data.first_event  = rd_head_ff.ev[0];
         out_data.first_slot   = rd_head_ff.slot[0];
         out_data.first_x      = rd_head_ff.x[0];
         out_data.first_y      = rd_head_ff.y[0];
         out_data.second_event = rd_head_ff.ev[1];
         out_data.second_slot  = rd_head_ff.slot[1];
         out_data.second_x     = rd_head_ff.x[1];
         out_data.second_y     = rd_head_ff.y[1];
      end
   end

endmodule

>>> sv/trcq_checker.sv
// Port-level checks of the touch report coalescing queue, bound to the top.
// Depends on trcq_pkg and touch_report_coalescing_queue_core.
module trcq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input trcq_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.irq_line) |->
         (rsp_data.entry_count == 2'd0 && rsp_data.finger_count == 2'd0))
      else $error("fields set with no active report");

   a_active_entries: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.irq_line) |->
         (rsp_data.entry_count != 2'd0 && rsp_data.entry_count != 2'd3))
      else $error("active report with bad entry count");

   a_fingers: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.finger_count <= rsp_data.entry_count))
      else $error("more fingers than entries");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind touch_report_coalescing_queue_core trcq_checker u_trcq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
